[src/expression_char_tokenizer_defines.svh]
// assertion macros used by the tokenizer checker
`ifndef EXPRESSION_CHAR_TOKENIZER_DEFINES_SVH
`define EXPRESSION_CHAR_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ECT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ect_pkg.sv]
// shared types, constants and character classes for the expression tokenizer
package ect_pkg;

  localparam logic [2:0] KindNum    = 3'd0;
  localparam logic [2:0] KindId     = 3'd1;
  localparam logic [2:0] KindStr    = 3'd2;
  localparam logic [2:0] KindSingle = 3'd3;
  localparam logic [2:0] KindEnd    = 3'd4;

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChQuote = 8'h22;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);
  localparam int FifoCw    = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tbyte;
    logic       bvalid;
    logic       tend;
    logic       last;
  } result_t;

  // all results caused by one input item
  typedef struct packed {
    logic    two;
    result_t r1;
    result_t r0;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

[src/expression_char_tokenizer.sv]
// top level of the streaming expression tokenizer
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid_i/in_stall_o | char_code_i, end_of_text_i
//   output  | out       | out_valid_o/out_stall_i | token_kind_o, token_byte_o,
//           |           |                      | byte_valid_o, token_end_o, last_result_o
//
// one character per cycle while the queue is not full; an item that yields two results holds the back end for both
// first result goes through the queue and then the output register; items with no result emit nothing
// a four-entry queue between front and back end; in_stall_o rises only when it is full
// output stall backs up into the queue, never into the front end classification directly
// rst_ni clears the token mode to idle, the queue and the output valid flag
module expression_char_tokenizer import ect_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] token_byte_o,
  output logic       byte_valid_o,
  output logic       token_end_o,
  output logic       last_result_o
);

  logic         push, pop;
  entry_t       entry, head;
  fifo_status_t status;

  ect_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .status_i      (status),
    .push_o        (push),
    .entry_o       (entry)
  );

  ect_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  ect_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .token_byte_o  (token_byte_o),
    .byte_valid_o  (byte_valid_o),
    .token_end_o   (token_end_o),
    .last_result_o (last_result_o)
  );

endmodule

[src/ect_front.sv]
// front end: classifies each character, tracks the token mode, builds result entries
module ect_front import ect_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   char_code_i,
  input  logic         end_of_text_i,
  input  fifo_status_t status_i,
  output logic         push_o,
  output entry_t       entry_o
);

  typedef enum logic [1:0] {ModeIdle, ModeNum, ModeId, ModeStr} mode_e;

  mode_e   mode_q, mode_d;
  mode_e   st_mode;
  logic    st_has;
  result_t st_res;
  result_t r0, r1;
  logic [1:0] n;
  logic    accept;
  logic [2:0] mode_kind;

  always_comb begin
    case (mode_q)
      ModeNum: mode_kind = KindNum;
      ModeId:  mode_kind = KindId;
      ModeStr: mode_kind = KindStr;
      default: mode_kind = KindEnd;
    endcase
  end

  // what the character does when no token is open
  always_comb begin
    st_res  = '0;
    st_has  = 1'b0;
    st_mode = ModeIdle;
    if (is_space(char_code_i)) begin
      st_has = 1'b0;
    end else if (is_digit(char_code_i)) begin
      st_has  = 1'b1;
      st_mode = ModeNum;
      st_res  = '{kind: KindNum, tbyte: char_code_i, bvalid: 1'b1, tend: 1'b0, last: 1'b0};
    end else if (is_alpha(char_code_i)) begin
      st_has  = 1'b1;
      st_mode = ModeId;
      st_res  = '{kind: KindId, tbyte: char_code_i, bvalid: 1'b1, tend: 1'b0, last: 1'b0};
    end else if (char_code_i == ChQuote) begin
      st_mode = ModeStr;
    end else begin
      st_has = 1'b1;
      st_res = '{kind: KindSingle, tbyte: char_code_i, bvalid: 1'b1, tend: 1'b1, last: 1'b0};
    end
  end

  always_comb begin
    result_t close_res;
    logic    more;
    close_res = '{kind: mode_kind, tbyte: 8'h00, bvalid: 1'b0, tend: 1'b1, last: 1'b0};
    more      = 1'b0;
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    mode_d = mode_q;
    if (end_of_text_i) begin
      mode_d = ModeIdle;
      if (mode_q != ModeIdle) begin
        r0 = close_res;
        r1 = '{kind: KindEnd, tbyte: 8'h00, bvalid: 1'b0, tend: 1'b1, last: 1'b0};
        n  = 2'd2;
      end else begin
        r0 = '{kind: KindEnd, tbyte: 8'h00, bvalid: 1'b0, tend: 1'b1, last: 1'b0};
        n  = 2'd1;
      end
    end else begin
      case (mode_q)
        ModeIdle: begin
          r0     = st_res;
          n      = {1'b0, st_has};
          mode_d = st_mode;
        end
        ModeStr: begin
          n = 2'd1;
          if (char_code_i == ChQuote) begin
            r0     = close_res;
            mode_d = ModeIdle;
          end else begin
            r0 = '{kind: KindStr, tbyte: char_code_i, bvalid: 1'b1, tend: 1'b0, last: 1'b0};
          end
        end
        default: begin
          if (mode_q == ModeNum) begin
            more = is_digit(char_code_i) || (char_code_i == ChDot);
          end else begin
            more = is_digit(char_code_i) || is_alpha(char_code_i);
          end
          if (more) begin
            r0 = '{kind: mode_kind, tbyte: char_code_i, bvalid: 1'b1, tend: 1'b0, last: 1'b0};
            n  = 2'd1;
          end else begin
            // close the open token, then start over on this character
            r0     = close_res;
            r1     = st_res;
            n      = st_has ? 2'd2 : 2'd1;
            mode_d = st_mode;
          end
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign in_stall_o = status_i.full;
  assign accept     = in_valid_i && !status_i.full;
  assign push_o     = accept && (n != 2'd0);
  assign entry_o    = '{two: (n == 2'd2), r1: r1, r0: r0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

endmodule

[src/ect_fifo.sv]
// short register queue of result entries between front and back end
module ect_fifo import ect_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  entry_t       entry_i,
  input  logic         pop_i,
  output entry_t       head_o,
  output fifo_status_t status_o
);

  entry_t              mem_q [FifoDepth];
  logic [FifoAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FifoCw-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign status_o.full  = (cnt_q == FifoCw'(FifoDepth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[src/ect_back.sv]
// back end: walks each entry one result per cycle into the output register while the output is not stalled
module ect_back import ect_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  entry_t       head_i,
  input  fifo_status_t status_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [2:0]   token_kind_o,
  output logic [7:0]   token_byte_o,
  output logic         byte_valid_o,
  output logic         token_end_o,
  output logic         last_result_o
);

  logic    out_valid_q;
  result_t out_q;
  logic    sel_q;
  logic    load;
  logic    is_last;
  result_t cur;

  assign load    = !out_valid_q || !out_stall_i;
  assign cur     = sel_q ? head_i.r1 : head_i.r0;
  assign is_last = !head_i.two || sel_q;
  // entry leaves the queue with its final result
  assign pop_o   = load && !status_i.empty && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= !status_i.empty;
      if (!status_i.empty) begin
        sel_q <= !is_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !status_i.empty) begin
      out_q <= cur;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = out_q.kind;
  assign token_byte_o  = out_q.tbyte;
  assign byte_valid_o  = out_q.bvalid;
  assign token_end_o   = out_q.tend;
  assign last_result_o = out_q.last;

endmodule

[src/ect_checker.sv]
// port-level checker for the tokenizer and its bind
`include "expression_char_tokenizer_defines.svh"

module ect_checker import ect_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_code_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] token_kind_o,
  input logic [7:0] token_byte_o,
  input logic       byte_valid_o,
  input logic       token_end_o,
  input logic       last_result_o
);

  logic out_held;
  logic [12:0] out_payload;
  logic in_held;
  logic [8:0] in_payload;

  assign out_payload = {token_kind_o, token_byte_o, byte_valid_o, token_end_o};
  assign out_held    = out_valid_o && out_stall_i;
  assign in_payload  = {char_code_i, end_of_text_i};
  assign in_held     = in_valid_i && in_stall_o;

  `ECT_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_payload) && $stable(last_result_o), "stalled transaction changed")
  `ECT_ASSERT_NEXT(a_in_hold, in_held, in_valid_i && $stable(in_payload), "stalled input transaction changed")
  `ECT_ASSERT_NOW(a_no_byte_zero, out_valid_o && !byte_valid_o, token_byte_o == 8'h00, "token_byte not zero without data")
  `ECT_ASSERT_NOW(a_end_kind, out_valid_o && (token_kind_o == KindEnd), token_end_o && last_result_o && !byte_valid_o, "end token malformed")
  `ECT_ASSERT_NOW(a_single_kind, out_valid_o && (token_kind_o == KindSingle), token_end_o && byte_valid_o, "single-character token malformed")

endmodule

bind expression_char_tokenizer ect_checker u_ect_checker (.*);
